### src/mrrc_pkg.sv
// Shared types, constants and the byte-wide CRC-16/Modbus update for the
// Modbus read-response checker. No dependencies.
package mrrc_pkg;

	localparam int unsigned IDX_W = 9;
	localparam logic [IDX_W-1:0] IDX_MAX = '1;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0] ADDR_RESET = 8'h01;
	localparam logic [7:0] MIN_DATA_BYTES = 8'd4;
	localparam logic [9:0] MIN_FRAME_LEN = 10'd5;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_SHORT    = 3'd1,
		ERR_ADDRESS  = 3'd2,
		ERR_FUNCTION = 3'd3,
		ERR_LENGTH   = 3'd4,
		ERR_CRC      = 3'd5,
		ERR_FEW_DATA = 3'd6
	} err_code_t;

	typedef enum logic [0:0] {
		REG_DEVICE_ADDRESS = 1'b0
	} reg_idx_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

### src/modbus_read_response_checker.sv
// Modbus RTU read-holding-registers reply checker: single-pass byte datapath
// with an output register. Depends on mrrc_pkg.
//
// Takes one reply byte per beat (frame_last on the final byte) and gives one
// verdict beat per frame, at the frame's last byte. The CRC-16/Modbus update
// is an unrolled eight-step shift network, and the header, count, data and
// received-CRC fields are captured in the same cycle as the CRC update.
// The verdict sits in an output register; in_ready stays high while that
// register is empty or being drained, so bytes stream at one per cycle.
// device_address (APB offset 0x0, reset 0x01) is compared against byte 0 when
// it arrives; write it only while no frame is in progress. Readings are raw
// big-endian words in tenths and read as zero on any error.
module modbus_read_response_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        frame_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_ok,
	output logic [2:0]  error_code,
	output logic [15:0] raw_temperature,
	output logic [15:0] raw_humidity
);
	import mrrc_pkg::*;

	logic [7:0]       device_address_q;
	logic [IDX_W-1:0] byte_index_q;
	logic [15:0]      crc_running_q;
	logic [15:0]      crc_snapshot_q;
	logic [7:0]       count_field_q;
	logic [1:0]       header_flags_q;
	logic [15:0]      crc_received_q;
	logic [15:0]      temperature_word_q;
	logic [15:0]      humidity_word_q;

	logic             out_valid_q;
	logic             frame_ok_q;
	err_code_t        error_code_q;
	logic [15:0]      raw_temperature_q;
	logic [15:0]      raw_humidity_q;

	logic             reg_hit;
	logic             accept;
	logic [7:0]       count_next;
	logic [1:0]       flags_next;
	logic [15:0]      crc_next;
	logic [15:0]      snap_next;
	logic [15:0]      rcv_next;
	logic [15:0]      temp_next;
	logic [15:0]      hum_next;
	logic [9:0]       frame_len;
	logic [9:0]       expect_len;
	err_code_t        err;

	// config port
	assign pready  = 1'b1;
	assign reg_hit = (paddr == {1'b0, REG_DEVICE_ADDRESS});
	assign prdata  = reg_hit ? {24'h000000, device_address_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= ADDR_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			device_address_q <= pwdata[7:0];
		end
	end

	// byte datapath
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		count_next = (byte_index_q == IDX_W'(2)) ? rx_byte : count_field_q;
		flags_next = header_flags_q;
		if (byte_index_q == IDX_W'(0) && rx_byte == device_address_q) begin
			flags_next[0] = 1'b1;
		end
		if (byte_index_q == IDX_W'(1) && rx_byte == FUNC_READ_HOLDING) begin
			flags_next[1] = 1'b1;
		end
		crc_next  = crc_byte(crc_running_q, rx_byte);
		snap_next = crc_snapshot_q;
		if (byte_index_q >= IDX_W'(2)
				&& byte_index_q == IDX_W'(2) + {1'b0, count_next}) begin
			snap_next = crc_next;
		end
		rcv_next  = {rx_byte, crc_received_q[15:8]};
		temp_next = temperature_word_q;
		hum_next  = humidity_word_q;
		if (byte_index_q == IDX_W'(3)) temp_next[15:8] = rx_byte;
		if (byte_index_q == IDX_W'(4)) temp_next[7:0]  = rx_byte;
		if (byte_index_q == IDX_W'(5)) hum_next[15:8]  = rx_byte;
		if (byte_index_q == IDX_W'(6)) hum_next[7:0]   = rx_byte;

		frame_len  = {1'b0, byte_index_q} + 10'd1;
		expect_len = MIN_FRAME_LEN + {2'b00, count_next};
		if (frame_len < MIN_FRAME_LEN) begin
			err = ERR_SHORT;
		end else if (!flags_next[0]) begin
			err = ERR_ADDRESS;
		end else if (!flags_next[1]) begin
			err = ERR_FUNCTION;
		end else if (frame_len != expect_len) begin
			err = ERR_LENGTH;
		end else if (snap_next != rcv_next) begin
			err = ERR_CRC;
		end else if (count_next < MIN_DATA_BYTES) begin
			err = ERR_FEW_DATA;
		end else begin
			err = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q       <= '0;
			crc_running_q      <= CRC_INIT;
			crc_snapshot_q     <= '0;
			count_field_q      <= '0;
			header_flags_q     <= '0;
			crc_received_q     <= '0;
			temperature_word_q <= '0;
			humidity_word_q    <= '0;
		end else if (accept) begin
			if (frame_last) begin
				byte_index_q       <= '0;
				crc_running_q      <= CRC_INIT;
				crc_snapshot_q     <= '0;
				count_field_q      <= '0;
				header_flags_q     <= '0;
				crc_received_q     <= '0;
				temperature_word_q <= '0;
				humidity_word_q    <= '0;
			end else begin
				if (byte_index_q != IDX_MAX) begin
					byte_index_q <= byte_index_q + IDX_W'(1);
				end
				crc_running_q      <= crc_next;
				crc_snapshot_q     <= snap_next;
				count_field_q      <= count_next;
				header_flags_q     <= flags_next;
				crc_received_q     <= rcv_next;
				temperature_word_q <= temp_next;
				humidity_word_q    <= hum_next;
			end
		end
	end

	// verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && frame_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_last) begin
			frame_ok_q        <= (err == ERR_NONE);
			error_code_q      <= err;
			raw_temperature_q <= (err == ERR_NONE) ? temp_next : 16'h0000;
			raw_humidity_q    <= (err == ERR_NONE) ? hum_next : 16'h0000;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_ok        = frame_ok_q;
	assign error_code      = error_code_q;
	assign raw_temperature = raw_temperature_q;
	assign raw_humidity    = raw_humidity_q;

	a_ok_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_ok == (error_code == ERR_NONE)))
		else $error("frame_ok disagrees with error_code");

	a_fail_zero_readings: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_ok |-> raw_temperature == 16'h0000 && raw_humidity == 16'h0000)
		else $error("readings not cleared on failed frame");

	a_last_clears_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_last |=> byte_index_q == '0 && crc_running_q == CRC_INIT
			&& header_flags_q == 2'b00 && out_valid)
		else $error("frame state not cleared after last beat");

	a_index_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !frame_last && byte_index_q != IDX_MAX
			|=> byte_index_q == $past(byte_index_q) + IDX_W'(1))
		else $error("byte index did not advance");

endmodule

### test/modbus_read_response_checker_tb.sv
// Testbench for modbus_read_response_checker: drives reply bytes and APB register
// writes, predicts each frame verdict in-line and checks every result beat.
// Depends on mrrc_pkg and the modbus_read_response_checker RTL.
`timescale 1ns / 100ps

module modbus_read_response_checker_tb;
	import mrrc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic        ok;
		err_code_t   err;
		logic [15:0] temperature;
		logic [15:0] humidity;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        frame_last;
	logic        out_valid;
	logic        out_ready;
	logic        frame_ok;
	logic [2:0]  error_code;
	logic [15:0] raw_temperature;
	logic [15:0] raw_humidity;

	// reply decoder state mirrored from the block
	logic [7:0]  dev_addr_m;
	logic [8:0]  frame_pos;
	logic [15:0] crc_acc;
	logic [15:0] crc_at_end;
	logic [7:0]  count_byte;
	logic        addr_matched;
	logic        func_matched;
	logic [15:0] crc_tail;
	logic [15:0] temp_word;
	logic [15:0] hum_word;

	verdict_t    expected_verdicts[$];
	logic [7:0]  reply_bytes[$];
	verdict_t    want;
	int          errors;
	int          bytes_sent;
	int          frames_sent;
	int          verdict_seen[8];
	int          send_idle_pct;
	int          recv_stall_pct;
	int unsigned cycle_count;

	modbus_read_response_checker uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.frame_last(frame_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_ok(frame_ok),
		.error_code(error_code),
		.raw_temperature(raw_temperature),
		.raw_humidity(raw_humidity)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d verdicts outstanding", $time, expected_verdicts.size());
			$display("FAIL modbus_read_response_checker");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] r;
		r = crc_in ^ {8'h00, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	task automatic clear_frame_model();
		frame_pos = '0;
		crc_acc = CRC_INIT;
		crc_at_end = '0;
		count_byte = '0;
		addr_matched = 1'b0;
		func_matched = 1'b0;
		crc_tail = '0;
		temp_word = '0;
		hum_word = '0;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic last);
		int pos;
		int len;
		verdict_t v;
		pos = int'(frame_pos);
		if (pos == 0 && b == dev_addr_m) addr_matched = 1'b1;
		if (pos == 1 && b == FUNC_READ_HOLDING) func_matched = 1'b1;
		case (pos)
			2: count_byte = b;
			3: temp_word[15:8] = b;
			4: temp_word[7:0] = b;
			5: hum_word[15:8] = b;
			6: hum_word[7:0] = b;
			default: ;
		endcase
		crc_acc = crc16_step(crc_acc, b);
		if (pos >= 2 && pos == 2 + int'(count_byte)) crc_at_end = crc_acc;
		crc_tail = {b, crc_tail[15:8]};
		if (frame_pos != IDX_MAX) frame_pos = frame_pos + 1'b1;
		if (last) begin
			len = pos + 1;
			if (len < int'(MIN_FRAME_LEN)) v.err = ERR_SHORT;
			else if (!addr_matched) v.err = ERR_ADDRESS;
			else if (!func_matched) v.err = ERR_FUNCTION;
			else if (len != int'(MIN_FRAME_LEN) + int'(count_byte)) v.err = ERR_LENGTH;
			else if (crc_at_end != crc_tail) v.err = ERR_CRC;
			else if (count_byte < MIN_DATA_BYTES) v.err = ERR_FEW_DATA;
			else v.err = ERR_NONE;
			v.ok = (v.err == ERR_NONE);
			v.temperature = v.ok ? temp_word : 16'h0000;
			v.humidity = v.ok ? hum_word : 16'h0000;
			expected_verdicts.push_back(v);
			frames_sent++;
			clear_frame_model();
		end
	endtask

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				errors++;
				$display("%0t: verdict beat with none expected, expected none actual ok=%0d err=%0d",
					$time, frame_ok, error_code);
			end else begin
				want = expected_verdicts.pop_front();
				check_field("frame_ok", want.ok, frame_ok);
				check_field("error_code", want.err, error_code);
				check_field("raw_temperature", want.temperature, raw_temperature);
				check_field("raw_humidity", want.humidity, raw_humidity);
				verdict_seen[error_code]++;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_last <= last;
		do @(posedge clk); while (!in_ready);
		predict_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (reply_bytes[i]) send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
	endtask

	// hold off the sender until every verdict is back, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 2'(4 * int'(idx));
		pwdata <= {24'h000000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		dev_addr_m = val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (prdata[7:0] !== val) begin
			errors++;
			$display("%0t: device_address readback, expected %0d actual %0d",
				$time, val, prdata[7:0]);
		end
	endtask

	task automatic build_reply(input logic [7:0] addr, input logic [7:0] func, input int count,
			input int fill);
		logic [15:0] crc;
		reply_bytes.delete();
		reply_bytes.push_back(addr);
		reply_bytes.push_back(func);
		reply_bytes.push_back(8'(count));
		for (int i = 0; i < count; i++)
			reply_bytes.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
		crc = CRC_INIT;
		foreach (reply_bytes[i]) crc = crc16_step(crc, reply_bytes[i]);
		reply_bytes.push_back(crc[7:0]);
		reply_bytes.push_back(crc[15:8]);
	endtask

	task automatic test_reset_address();
		build_reply(ADDR_RESET, FUNC_READ_HOLDING, 4, -1);
		send_frame();
		build_reply(ADDR_RESET ^ 8'h80, FUNC_READ_HOLDING, 4, -1);
		send_frame();
	endtask

	task automatic test_data_extremes();
		build_reply(dev_addr_m, FUNC_READ_HOLDING, 4, 8'hFF);
		send_frame();
		build_reply(dev_addr_m, FUNC_READ_HOLDING, 4, 8'h00);
		send_frame();
		build_reply(dev_addr_m, FUNC_READ_HOLDING, 255, -1);
		send_frame();
	endtask

	task automatic test_verdict_order();
		// single byte frame
		reply_bytes = '{dev_addr_m};
		send_frame();
		// four bytes with a bad function: too short wins
		reply_bytes = '{dev_addr_m, 8'h10, 8'h00, 8'h00};
		send_frame();
		build_reply(dev_addr_m ^ 8'h01, FUNC_READ_HOLDING, 4, -1);
		send_frame();
		build_reply(dev_addr_m ^ 8'h55, 8'h04, 4, -1);
		send_frame();
		build_reply(dev_addr_m, 8'h04, 4, -1);
		send_frame();
		build_reply(dev_addr_m, FUNC_READ_HOLDING, 4, -1);
		reply_bytes.push_back(8'hA5);
		send_frame();
		build_reply(dev_addr_m, FUNC_READ_HOLDING, 6, -1);
		void'(reply_bytes.pop_back());
		send_frame();
		build_reply(dev_addr_m, FUNC_READ_HOLDING, 4, -1);
		reply_bytes[7] = reply_bytes[7] ^ 8'h01;
		send_frame();
		build_reply(dev_addr_m, FUNC_READ_HOLDING, 5, -1);
		reply_bytes[9] = reply_bytes[9] ^ 8'h80;
		send_frame();
		// short data: valid CRC with fewer than four data bytes
		build_reply(dev_addr_m, FUNC_READ_HOLDING, 0, -1);
		send_frame();
		build_reply(dev_addr_m, FUNC_READ_HOLDING, 3, -1);
		send_frame();
	endtask

	task automatic test_address_register();
		drain();
		reg_write(REG_DEVICE_ADDRESS, 8'h00);
		build_reply(8'h00, FUNC_READ_HOLDING, 4, -1);
		send_frame();
		build_reply(ADDR_RESET, FUNC_READ_HOLDING, 4, -1);
		send_frame();
		drain();
		reg_write(REG_DEVICE_ADDRESS, 8'hFF);
		build_reply(8'hFF, FUNC_READ_HOLDING, 8, -1);
		send_frame();
		build_reply(8'hFE, FUNC_READ_HOLDING, 4, -1);
		send_frame();
		drain();
		reg_write(REG_DEVICE_ADDRESS, ADDR_RESET);
	endtask

	// byte position saturates shortly before the end of this frame
	task automatic test_long_frame();
		build_reply(dev_addr_m, FUNC_READ_HOLDING, 255, -1);
		while (reply_bytes.size() < 515) reply_bytes.push_back(8'($urandom_range(255)));
		send_frame();
		build_reply(dev_addr_m, FUNC_READ_HOLDING, 4, -1);
		send_frame();
	endtask

	task automatic random_reply();
		int kind;
		int pick;
		int n;
		int idx;
		kind = $urandom_range(99);
		pick = $urandom_range(9);
		n = pick < 6 ? $urandom_range(12, 4) : (pick < 8 ? $urandom_range(3, 0) : $urandom_range(40, 13));
		if (kind < 55) begin
			build_reply(dev_addr_m, FUNC_READ_HOLDING, n, -1);
		end else if (kind < 63) begin
			build_reply(dev_addr_m ^ 8'($urandom_range(255, 1)), FUNC_READ_HOLDING, n, -1);
		end else if (kind < 70) begin
			build_reply(dev_addr_m, FUNC_READ_HOLDING ^ 8'($urandom_range(255, 1)), n, -1);
		end else if (kind < 78) begin
			build_reply(dev_addr_m, FUNC_READ_HOLDING, n, -1);
			idx = $urandom_range(reply_bytes.size() - 1);
			reply_bytes[idx] = reply_bytes[idx] ^ (8'h01 << $urandom_range(7));
		end else if (kind < 86) begin
			build_reply(dev_addr_m, FUNC_READ_HOLDING, n, -1);
			if ($urandom_range(1)) begin
				repeat ($urandom_range(3, 1)) reply_bytes.push_back(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(3, 1)) void'(reply_bytes.pop_back());
			end
		end else if (kind < 93) begin
			reply_bytes.delete();
			reply_bytes.push_back($urandom_range(1) ? dev_addr_m : 8'($urandom_range(255)));
			repeat ($urandom_range(3, 0)) reply_bytes.push_back(8'($urandom_range(255)));
		end else begin
			reply_bytes.delete();
			repeat ($urandom_range(20, 1)) reply_bytes.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic test_random_traffic();
		logic [7:0] addr_plan[4];
		int send_plan[4];
		int recv_plan[4];
		int start;
		addr_plan = '{8'h00, 8'hFF, 8'($urandom_range(255)), ADDR_RESET};
		send_plan = '{0, 73, 0, 35};
		recv_plan = '{0, 0, 73, 35};
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			reg_write(REG_DEVICE_ADDRESS, addr_plan[ph]);
			send_idle_pct = send_plan[ph];
			recv_stall_pct = recv_plan[ph];
			start = bytes_sent;
			while (bytes_sent - start < 160) begin
				if ($urandom_range(19) == 0) drain();
				random_reply();
				send_frame();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		frame_last = 1'b0;
		out_ready = 1'b0;
		errors = 0;
		bytes_sent = 0;
		frames_sent = 0;
		cycle_count = 0;
		send_idle_pct = 20;
		recv_stall_pct = 20;
		dev_addr_m = ADDR_RESET;
		clear_frame_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_address();
		test_data_extremes();
		test_verdict_order();
		test_address_register();
		test_long_frame();
		test_random_traffic();

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d frames in %0d bytes over four idle/stall mixes and four addresses",
			frames_sent, bytes_sent);
		$display("Verdicts by code 0..6: %0d %0d %0d %0d %0d %0d %0d", verdict_seen[0],
			verdict_seen[1], verdict_seen[2], verdict_seen[3], verdict_seen[4],
			verdict_seen[5], verdict_seen[6]);
		if (errors == 0) begin
			$display("PASS modbus_read_response_checker");
		end else begin
			$display("FAIL modbus_read_response_checker");
		end
		$finish;
	end

endmodule
